FILE: sv/frml_pkg.sv
// Shared constants, types and width helpers for the frame rate meter and limiter.
`default_nettype none

package frml_pkg;

   // Field widths fixed by the interface.
   localparam int STAMP_W    = 32;
   localparam int FT_W       = 16;
   localparam int FPS_W      = 22;
   localparam int DELAY_W    = 10;
   localparam int MAX_FPS_W  = 10;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_MAX_FPS = 1'd0;

   // Defaults and arithmetic constants.
   localparam int                    WINDOW_DEF      = 10;
   localparam logic [MAX_FPS_W-1:0]  MAX_FPS_RESET   = 10'd60;
   localparam int                    RATE_SCALE      = 256000;
   localparam logic [FPS_W-1:0]      FALLBACK_FPS_Q8 = 22'd15360;
   localparam logic [FPS_W-1:0]      FPS_MAX         = 22'h3FFFFF;
   localparam logic [DELAY_W-1:0]    BUDGET_MS       = 10'd1000;
   localparam logic [FT_W-1:0]       FRAME_TIME_MAX  = 16'hFFFF;

   // Control from the sequencer to the frame time window.
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } win_ctrl_type;

   function automatic int sum_w(input int window);
      sum_w = $clog2(window * 65535 + 1);
   endfunction

   function automatic int cnt_w(input int window);
      cnt_w = $clog2(window + 1);
   endfunction

   function automatic int slot_w(input int window);
      slot_w = (window > 1) ? $clog2(window) : 1;
   endfunction

   function automatic int num_w(input int window);
      num_w = $clog2(RATE_SCALE * window + 1);
   endfunction

endpackage

`default_nettype wire

FILE: sv/frml_serial_sub.sv
// Bit-serial subtractor: forms a minus b modulo 2^W, one bit per cycle, LSB first.
`default_nettype none

module frml_serial_sub #(
   parameter int W = frml_pkg::STAMP_W
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         load,
   input  wire logic [W-1:0] a,
   input  wire logic [W-1:0] b,
   output logic              busy,
   output logic [W-1:0]      diff
);

   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  a_ff, a_in;
   logic [W-1:0]  b_ff, b_in;
   logic [W-1:0]  d_ff, d_in;
   logic          borrow_ff, borrow_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          bit_d;

   always_comb begin
      a_in      = a_ff;
      b_in      = b_ff;
      d_in      = d_ff;
      borrow_in = borrow_ff;
      cnt_in    = cnt_ff;
      bit_d     = a_ff[0] ^ b_ff[0] ^ borrow_ff;
      if (load) begin
         a_in      = a;
         b_in      = b;
         borrow_in = 1'b0;
         cnt_in    = CW'(W);
      end else if (cnt_ff != '0) begin
         a_in      = {1'b0, a_ff[W-1:1]};
         b_in      = {1'b0, b_ff[W-1:1]};
         d_in      = {bit_d, d_ff[W-1:1]};
         borrow_in = (~a_ff[0] & b_ff[0]) | (~(a_ff[0] ^ b_ff[0]) & borrow_ff);
         cnt_in    = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      a_ff      <= a_in;
      b_ff      <= b_in;
      d_ff      <= d_in;
      borrow_ff <= borrow_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign busy = (cnt_ff != '0);
   assign diff = d_ff;

endmodule

`default_nettype wire

FILE: sv/frml_serial_div.sv
// Radix-2 restoring divider that retires one quotient bit per cycle.
`default_nettype none

module frml_serial_div #(
   parameter int NW = frml_pkg::DELAY_W,
   parameter int DW = frml_pkg::MAX_FPS_W
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] num,
   input  wire logic [DW-1:0] den,
   output logic               busy,
   output logic [NW-1:0]      quot
);

   localparam int CW = $clog2(NW + 1);

   logic [DW-1:0] rem_ff, rem_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW:0]   trial;
   logic          fits;

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      trial  = {rem_ff, quo_ff[NW-1]};
      fits   = (trial >= {1'b0, den});
      if (start) begin
         rem_in = '0;
         quo_in = num;
         cnt_in = CW'(NW);
      end else if (cnt_ff != '0) begin
         rem_in = fits ? DW'(trial - {1'b0, den}) : DW'(trial);
         quo_in = {quo_ff[NW-2:0], fits};
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign busy = (cnt_ff != '0);
   assign quot = quo_ff;

endmodule

`default_nettype wire

FILE: sv/frml_window.sv
// Ring of recent frame times with its running sum, fill count and write slot.
`default_nettype none

module frml_window #(
   parameter int WINDOW = frml_pkg::WINDOW_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire frml_pkg::win_ctrl_type             ctrl,
   input  wire logic [frml_pkg::FT_W-1:0]          ft,
   output logic [frml_pkg::sum_w(WINDOW)-1:0]      sum,
   output logic [frml_pkg::cnt_w(WINDOW)-1:0]      fill
);

   localparam int SUM_W  = frml_pkg::sum_w(WINDOW);
   localparam int CNT_W  = frml_pkg::cnt_w(WINDOW);
   localparam int SLOT_W = frml_pkg::slot_w(WINDOW);

   logic [frml_pkg::FT_W-1:0] ring_mem [WINDOW];
   logic [frml_pkg::FT_W-1:0] old_ff;
   logic [frml_pkg::FT_W-1:0] old_val;
   logic [SLOT_W-1:0]         slot_ff, slot_in;
   logic [CNT_W-1:0]          fill_ff, fill_in;
   logic [SUM_W-1:0]          sum_ff, sum_in;
   logic                      full;

   // Slots are filled in order, so an entry beyond the fill count was never written.
   assign full    = (fill_ff == CNT_W'(WINDOW));
   assign old_val = full ? old_ff : '0;

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         old_ff <= ring_mem[slot_ff];
      end
      if (ctrl.wr_en) begin
         ring_mem[slot_ff] <= ft;
      end
   end

   always_comb begin
      slot_in = slot_ff;
      fill_in = fill_ff;
      sum_in  = sum_ff;
      if (ctrl.wr_en) begin
         sum_in  = sum_ff - SUM_W'(old_val) + SUM_W'(ft);
         slot_in = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + SLOT_W'(1);
         fill_in = full ? fill_ff : fill_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         fill_ff <= '0;
         sum_ff  <= '0;
      end else begin
         slot_ff <= slot_in;
         fill_ff <= fill_in;
         sum_ff  <= sum_in;
      end
   end

   assign sum  = sum_ff;
   assign fill = fill_ff;

   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(WINDOW))
      else $error("fill count above window depth");

   a_empty_sum : assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0) |-> (sum_ff == '0))
      else $error("running sum non-zero with empty window");

   a_slot_tracks_fill : assert property (@(posedge clock) disable iff (reset)
      !full |-> (32'(slot_ff) == 32'(fill_ff)))
      else $error("write slot out of step with fill count");

endmodule

`default_nettype wire

FILE: sv/frame_rate_meter_limiter.sv
// Top level of the frame rate meter and limiter: sequencer, register port and result stage.
`default_nettype none

// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  frame_start_ms, now_ms
// rsp_      out        rsp_valid / rsp_stall  frame_time_ms, fps_q8, delay_ms
// csr_      in/out     APB-style, pready=1    max_fps at byte address 0
//
// Each transaction runs from acceptance to a ready result through these steps: the 32-bit
// bit-serial subtractors that form the frame time and elapsed time, the window update, the
// load of the rate divider, its division at one quotient bit per cycle (22 bits with the
// default window), the exit from the division and the load of the result stage.
// Reset is synchronous and active high; it clears the window, the register to 60 and the
// handshake state. The ring of frame times needs no clearing pass, as the fill count masks it.
// A new transaction is accepted while a finished result is still held on the result port; the
// sequencer only waits at its last step if that earlier result has not yet been taken.

module frame_rate_meter_limiter #(
   parameter int WINDOW = frml_pkg::WINDOW_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Request channel.
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [frml_pkg::STAMP_W-1:0]       req_frame_start_ms,
   input  wire logic [frml_pkg::STAMP_W-1:0]       req_now_ms,
   // Result channel.
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [frml_pkg::FT_W-1:0]               rsp_frame_time_ms,
   output logic [frml_pkg::FPS_W-1:0]              rsp_fps_q8,
   output logic [frml_pkg::DELAY_W-1:0]            rsp_delay_ms,
   // Register port.
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [frml_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [frml_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [frml_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                    csr_pready
);

   localparam int SUM_W = frml_pkg::sum_w(WINDOW);
   localparam int CNT_W = frml_pkg::cnt_w(WINDOW);
   localparam int NUM_W = frml_pkg::num_w(WINDOW);
   localparam int STW   = frml_pkg::STAMP_W;
   localparam int FT_W  = frml_pkg::FT_W;
   localparam int DLY_W = frml_pkg::DELAY_W;
   localparam int MFW   = frml_pkg::MAX_FPS_W;

   // Sequencer states.
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SUB  = 3'd1;
   localparam logic [2:0] ST_DIVS = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   logic [2:0]     state_ff, state_in;
   logic [MFW-1:0] max_fps_ff, max_fps_in;
   logic [STW-1:0] prev_ff, prev_in;
   logic           seen_ff, seen_in;
   logic [FT_W-1:0] ft_ff, ft_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [FT_W-1:0]      rsp_ft_ff;
   logic [frml_pkg::FPS_W-1:0] rsp_fps_ff;
   logic [DLY_W-1:0]     rsp_delay_ff;

   logic           req_take;
   logic           out_free;
   logic           load_out;

   logic           ft_busy, el_busy;
   logic [STW-1:0] ft_diff, el_diff;
   logic [FT_W-1:0] ft_now;

   logic           bud_busy;
   logic [DLY_W-1:0] bud_quot;
   logic [MFW-1:0] limit;

   logic           fps_start, fps_busy;
   logic [NUM_W-1:0] fps_num, fps_quot;
   logic [frml_pkg::FPS_W-1:0] fps_val;
   logic [DLY_W-1:0] delay_val;

   frml_pkg::win_ctrl_type win_ctrl;
   logic [SUM_W-1:0] win_sum;
   logic [CNT_W-1:0] win_fill;

   logic                           csr_wr;
   logic [frml_pkg::CSR_IDX_W-1:0] csr_idx;

   // ---------------------------------------------------------------------------------------
   // Register port. Writes land on the access cycle; reads are answered at once.
   // ---------------------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[frml_pkg::CSR_ADDR_W-1:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      max_fps_in = max_fps_ff;
      if (csr_wr && (csr_idx == frml_pkg::REG_MAX_FPS)) begin
         max_fps_in = csr_pwdata[MFW-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_idx == frml_pkg::REG_MAX_FPS) begin
         csr_prdata = frml_pkg::CSR_DATA_W'(max_fps_ff);
      end
   end

   // ---------------------------------------------------------------------------------------
   // Handshakes. The block takes a transaction only when the sequencer is idle; the result
   // stage is freed when its transaction is taken or it is empty.
   // ---------------------------------------------------------------------------------------
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid & ~req_stall;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign load_out  = (state_ff == ST_FIN) & out_free;

   // ---------------------------------------------------------------------------------------
   // Serial datapath. Both subtractors start on acceptance: one forms the time since the
   // previous frame end, the other the time spent in this frame. The frame budget division
   // starts at the same time from the limit, a zero limit being taken as one.
   // ---------------------------------------------------------------------------------------
   frml_serial_sub #(.W(STW)) u_ft_sub (
      .clock (clock),
      .reset (reset),
      .load  (req_take),
      .a     (req_now_ms),
      .b     (prev_ff),
      .busy  (ft_busy),
      .diff  (ft_diff)
   );

   frml_serial_sub #(.W(STW)) u_el_sub (
      .clock (clock),
      .reset (reset),
      .load  (req_take),
      .a     (req_now_ms),
      .b     (req_frame_start_ms),
      .busy  (el_busy),
      .diff  (el_diff)
   );

   assign limit = (max_fps_ff == '0) ? MFW'(1) : max_fps_ff;

   frml_serial_div #(.NW(DLY_W), .DW(MFW)) u_budget_div (
      .clock (clock),
      .reset (reset),
      .start (req_take),
      .num   (frml_pkg::BUDGET_MS),
      .den   (limit),
      .busy  (bud_busy),
      .quot  (bud_quot)
   );

   // The frame time saturates at its field width, and the first frame after reset counts as 0.
   always_comb begin
      if (!seen_ff) begin
         ft_now = '0;
      end else if (ft_diff[STW-1:FT_W] != '0) begin
         ft_now = frml_pkg::FRAME_TIME_MAX;
      end else begin
         ft_now = ft_diff[FT_W-1:0];
      end
   end

   assign win_ctrl.rd_en = req_take;
   assign win_ctrl.wr_en = (state_ff == ST_SUB) & ~ft_busy;

   frml_window #(.WINDOW(WINDOW)) u_window (
      .clock (clock),
      .reset (reset),
      .ctrl  (win_ctrl),
      .ft    (ft_now),
      .sum   (win_sum),
      .fill  (win_fill)
   );

   // The rate numerator is the fill count scaled by 1000 in Q8, taken from the updated window.
   assign fps_start = (state_ff == ST_DIVS);
   assign fps_num   = NUM_W'(win_fill) * NUM_W'(frml_pkg::RATE_SCALE);

   frml_serial_div #(.NW(NUM_W), .DW(SUM_W)) u_fps_div (
      .clock (clock),
      .reset (reset),
      .start (fps_start),
      .num   (fps_num),
      .den   (win_sum),
      .busy  (fps_busy),
      .quot  (fps_quot)
   );

   // An all-zero window reports the nominal 60 frames per second; large rates saturate.
   always_comb begin
      if (win_sum == '0) begin
         fps_val = frml_pkg::FALLBACK_FPS_Q8;
      end else if (32'(fps_quot) > 32'(frml_pkg::FPS_MAX)) begin
         fps_val = frml_pkg::FPS_MAX;
      end else begin
         fps_val = frml_pkg::FPS_W'(fps_quot);
      end
   end

   // No wait once the elapsed time reaches the budget, which also covers a start stamp
   // that lies after the end stamp.
   always_comb begin
      if ((el_diff[STW-1:DLY_W] != '0) || (el_diff[DLY_W-1:0] >= bud_quot)) begin
         delay_val = '0;
      end else begin
         delay_val = bud_quot - el_diff[DLY_W-1:0];
      end
   end

   // ---------------------------------------------------------------------------------------
   // Sequencer.
   // ---------------------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      prev_in  = prev_ff;
      seen_in  = seen_ff;
      ft_in    = ft_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               prev_in  = req_now_ms;
               state_in = ST_SUB;
            end
         end
         ST_SUB: begin
            if (!ft_busy) begin
               ft_in    = ft_now;
               seen_in  = 1'b1;
               state_in = ST_DIVS;
            end
         end
         ST_DIVS: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (!fps_busy && !bud_busy) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
      ft_ff   <= ft_in;
      if (load_out) begin
         rsp_ft_ff    <= ft_ff;
         rsp_fps_ff   <= fps_val;
         rsp_delay_ff <= delay_val;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         seen_ff      <= 1'b0;
         max_fps_ff   <= frml_pkg::MAX_FPS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         max_fps_ff   <= max_fps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_time_ms = rsp_ft_ff;
   assign rsp_fps_q8        = rsp_fps_ff;
   assign rsp_delay_ms      = rsp_delay_ff;

   a_sub_lockstep : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUB) |-> (ft_busy == el_busy))
      else $error("serial subtractors out of step");

   a_result_from_fin : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("result raised outside the final step");

   a_stall_while_busy : assert property (@(posedge clock) disable iff (reset)
      (ft_busy || fps_busy) |-> req_stall)
      else $error("request accepted while the datapath is busy");

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for the frame rate meter and limiter, with its own frame-time predictor.
`timescale 1ns / 1ps

module tb;

   // Widths and constants taken over from the shared package.
   localparam int STAMP_W    = frml_pkg::STAMP_W;
   localparam int FT_W       = frml_pkg::FT_W;
   localparam int FPS_W      = frml_pkg::FPS_W;
   localparam int DELAY_W    = frml_pkg::DELAY_W;
   localparam int MAX_FPS_W  = frml_pkg::MAX_FPS_W;
   localparam int CSR_DATA_W = frml_pkg::CSR_DATA_W;
   localparam int CSR_ADDR_W = frml_pkg::CSR_ADDR_W;
   localparam int CSR_IDX_W  = frml_pkg::CSR_IDX_W;
   localparam int RATE_SCALE = frml_pkg::RATE_SCALE;
   localparam logic [FT_W-1:0]    FRAME_TIME_MAX  = frml_pkg::FRAME_TIME_MAX;
   localparam logic [FPS_W-1:0]   FALLBACK_FPS_Q8 = frml_pkg::FALLBACK_FPS_Q8;
   localparam logic [FPS_W-1:0]   FPS_MAX         = frml_pkg::FPS_MAX;
   localparam logic [DELAY_W-1:0] BUDGET_MS       = frml_pkg::BUDGET_MS;

   // The ring length follows the block's default window, and the predictor uses the same value.
   localparam int RING_LEN        = frml_pkg::WINDOW_DEF;
   // The receiver holds off for this many cycles when asked, which fills the block up.
   localparam int HOLD_CYCLES     = 400;
   // No transaction on either channel for this many cycles means the block has hung.
   localparam int WATCHDOG_LIMIT  = 3000;
   // Idle tail at the end of the run, after every result has been taken.
   localparam int TAIL_CYCLES     = 120;
   localparam int RANDOM_PHASES   = 10;
   localparam int ITEMS_PER_PHASE = 180;

   localparam logic [CSR_IDX_W-1:0]  REG_UNMAPPED  = frml_pkg::REG_MAX_FPS + 1'b1;
   localparam logic [CSR_ADDR_W-1:0] ADDR_MAX_FPS  = {frml_pkg::REG_MAX_FPS, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNMAPPED = {REG_UNMAPPED, 2'b00};

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   // One result transaction as it appears on the rsp_ port.
   typedef struct packed {
      logic [FT_W-1:0]    frame_time;
      logic [FPS_W-1:0]   fps;
      logic [DELAY_W-1:0] delay;
   } frame_report_type;

   // One row of the directed table. A row either writes a register or sends a frame;
   // frame rows may carry a typed-in result, otherwise the predictor supplies it.
   typedef struct packed {
      logic                  set_limit;
      logic [CSR_ADDR_W-1:0] addr;
      logic [CSR_DATA_W-1:0] wdata;
      logic [STAMP_W-1:0]    start;
      logic [STAMP_W-1:0]    now;
      logic                  typed;
      logic [FT_W-1:0]       ft;
      logic [FPS_W-1:0]      fps;
      logic [DELAY_W-1:0]    dly;
   } plan_row_type;

   // Every input of the block starts from a known value.
   logic                  clock              = 1'b0;
   logic                  reset              = 1'b1;
   logic                  req_valid          = 1'b0;
   logic                  req_stall;
   logic [STAMP_W-1:0]    req_frame_start_ms = '0;
   logic [STAMP_W-1:0]    req_now_ms         = '0;
   logic                  rsp_valid;
   logic                  rsp_stall          = 1'b0;
   logic [FT_W-1:0]       rsp_frame_time_ms;
   logic [FPS_W-1:0]      rsp_fps_q8;
   logic [DELAY_W-1:0]    rsp_delay_ms;
   logic                  csr_psel           = 1'b0;
   logic                  csr_penable        = 1'b0;
   logic                  csr_pwrite         = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr          = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata         = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Predictor state: the last frame-end stamp, the ring of frame times with its running sum,
   // and the limit register as the testbench believes it to be.
   logic [STAMP_W-1:0]    last_stamp = '0;
   logic                  have_stamp = 1'b0;
   logic [FT_W-1:0]       frame_ring [RING_LEN];
   int unsigned           ring_pos   = 0;
   int unsigned           ring_fill  = 0;
   int unsigned           ring_sum   = 0;
   logic [MAX_FPS_W-1:0]  fps_limit  = frml_pkg::MAX_FPS_RESET;

   // Results that the block still owes, oldest first.
   frame_report_type      expected_reports [$];

   int                    errors          = 0;
   int                    items_sent      = 0;
   int                    results_checked = 0;
   int                    csr_writes      = 0;
   int                    idle_cycles     = 0;

   // The stimulus asks for a long hold-off by bumping hold_asks; the receiver answers it.
   int                    hold_asks = 0;
   int                    hold_done = 0;
   int                    hold_left = 0;
   int                    mode_left = 0;
   stall_mode_type        stall_mode = STALL_NONE;

   frame_rate_meter_limiter #(
      .WINDOW(RING_LEN)
   ) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_frame_start_ms (req_frame_start_ms),
      .req_now_ms         (req_now_ms),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_frame_time_ms  (rsp_frame_time_ms),
      .rsp_fps_q8         (rsp_fps_q8),
      .rsp_delay_ms       (rsp_delay_ms),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   always #4 clock = ~clock;

   // Works out the result of one accepted frame transaction and advances the predictor state.
   // The frame time saturates at 16 bits and is zero for the very first frame; the rate is
   // taken from the ring after it has been updated, and the wait is the per-frame budget less
   // the time the frame has already taken, never below zero.
   task automatic predict_frame(input logic [STAMP_W-1:0] start, input logic [STAMP_W-1:0] now,
                                output frame_report_type r);
      logic [STAMP_W-1:0] gap;
      logic [STAMP_W-1:0] elapsed;
      int unsigned        limit;
      int unsigned        budget;
      int unsigned        rate;
      gap = now - last_stamp;
      if (!have_stamp) begin
         r.frame_time = '0;
      end else if (gap > STAMP_W'(FRAME_TIME_MAX)) begin
         r.frame_time = FRAME_TIME_MAX;
      end else begin
         r.frame_time = gap[FT_W-1:0];
      end
      ring_sum = ring_sum - frame_ring[ring_pos] + r.frame_time;
      frame_ring[ring_pos] = r.frame_time;
      ring_pos = (ring_pos == RING_LEN - 1) ? 0 : ring_pos + 1;
      if (ring_fill < RING_LEN) begin
         ring_fill++;
      end
      last_stamp = now;
      have_stamp = 1'b1;

      // An empty sum of frame times falls back to 60 frames per second.
      if (ring_sum == 0) begin
         r.fps = FALLBACK_FPS_Q8;
      end else begin
         rate = (RATE_SCALE * ring_fill) / ring_sum;
         r.fps = (rate > FPS_MAX) ? FPS_MAX : rate[FPS_W-1:0];
      end

      // A limit of zero is taken as one frame per second.
      limit   = (fps_limit == 0) ? 1 : fps_limit;
      budget  = BUDGET_MS / limit;
      elapsed = now - start;
      r.delay = (elapsed >= budget) ? '0 : DELAY_W'(budget - elapsed);
   endtask

   // Offers one frame transaction and holds it until the block takes it. Valid is left high so
   // that a following transaction can go out back to back; the caller lowers it for a gap.
   task automatic send_frame(input logic [STAMP_W-1:0] start, input logic [STAMP_W-1:0] now,
                             input logic typed, input frame_report_type fixed);
      frame_report_type predicted;
      req_valid          <= 1'b1;
      req_frame_start_ms <= start;
      req_now_ms         <= now;
      do @(posedge clock); while (req_stall);
      items_sent++;
      predict_frame(start, now, predicted);
      expected_reports.push_back(typed ? fixed : predicted);
   endtask

   // Stops offering frames and waits until every owed result has been taken.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
   endtask

   // Optionally writes a register, then reads the limit register back and checks it. The read
   // setup follows the write access directly with psel held high.
   task automatic program_fps_limit(input logic do_write, input logic [CSR_ADDR_W-1:0] addr,
                                    input logic [CSR_DATA_W-1:0] data);
      if (do_write) begin
         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b1;
         csr_paddr   <= addr;
         csr_pwdata  <= data;
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         // Only the limit register exists; anything else is ignored by the block.
         if (addr == ADDR_MAX_FPS) begin
            fps_limit = data[MAX_FPS_W-1:0];
         end
         csr_writes++;
      end
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_MAX_FPS;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DATA_W'(fps_limit)) begin
         errors++;
         $display("%0t: max_fps read-back mismatch, expected %0d, got %0d",
                  $time, fps_limit, csr_prdata);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Result checker: every result transaction is compared with the oldest expectation.
   always @(posedge clock) begin : check_results
      frame_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_reports.size() == 0) begin
            errors++;
            $display("%0t: result with nothing outstanding, expected none, got %0d/%0d/%0d",
                     $time, rsp_frame_time_ms, rsp_fps_q8, rsp_delay_ms);
         end else begin
            want = expected_reports.pop_front();
            results_checked++;
            if (rsp_frame_time_ms !== want.frame_time) begin
               errors++;
               $display("%0t: frame_time_ms mismatch, expected %0d, got %0d",
                        $time, want.frame_time, rsp_frame_time_ms);
            end
            if (rsp_fps_q8 !== want.fps) begin
               errors++;
               $display("%0t: fps_q8 mismatch, expected %0d, got %0d",
                        $time, want.fps, rsp_fps_q8);
            end
            if (rsp_delay_ms !== want.delay) begin
               errors++;
               $display("%0t: delay_ms mismatch, expected %0d, got %0d",
                        $time, want.delay, rsp_delay_ms);
            end
         end
      end
   end

   // Receiver: it changes its stall pattern at random intervals, sometimes not stalling at
   // all, and on request holds off for a long stretch counted here.
   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_asks != hold_done) begin
            hold_done = hold_asks;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = stall_mode_type'($urandom_range(0, 3));
               mode_left  = $urandom_range(20, 300);
            end else begin
               mode_left--;
            end
            case (stall_mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 1) == 0);
               default:     rsp_stall <= ((mode_left % 9) < 4);
            endcase
         end
      end
   end

   // Watchdog: ends the run if neither channel completes a transaction for too long.
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      plan_row_type         plan [$];
      logic [MAX_FPS_W-1:0] phase_limits [RANDOM_PHASES];
      logic [STAMP_W-1:0]   stamp_clock;
      logic [STAMP_W-1:0]   step;
      logic [STAMP_W-1:0]   elapsed;
      int unsigned          budget;
      int                   directed_items;
      int                   sent;
      int                   burst;
      int                   gap;
      int                   pick;
      logic                 held;
      logic                 paused;
      logic                 dense;
      logic                 fast;

      for (int i = 0; i < RING_LEN; i++) begin
         frame_ring[i] = '0;
      end

      // Directed table. The first rows follow reset, so their results are typed in: the rate
      // falls back to 60 frames per second while every frame time is zero, and the wait is the
      // 16 ms budget of the reset limit less the elapsed time. The rows after that cover a
      // wrapping and a saturating frame time, a frame that overran its budget, a start stamp
      // after now, a zero limit, limits at and above 1000, upper write-data bits that must be
      // dropped and a write to an address with no register behind it.
      //                  lim   addr           wdata          start          now
      //                  typed ft      fps              delay
      plan.push_back('{1'b0, ADDR_MAX_FPS, 32'd0, 32'd0, 32'd0,
                       1'b1, 16'd0, FALLBACK_FPS_Q8, 10'd16});
      plan.push_back('{1'b0, ADDR_MAX_FPS, 32'd0, 32'd0, 32'd0,
                       1'b1, 16'd0, FALLBACK_FPS_Q8, 10'd16});
      plan.push_back('{1'b0, ADDR_MAX_FPS, 32'd0, 32'hFFFF_FFFF, 32'd0,
                       1'b1, 16'd0, FALLBACK_FPS_Q8, 10'd15});
      plan.push_back('{1'b0, ADDR_MAX_FPS, 32'd0, 32'd1, 32'd0,
                       1'b1, 16'd0, FALLBACK_FPS_Q8, 10'd0});
      plan.push_back('{1'b0, ADDR_MAX_FPS, 32'd0, 32'd0, 32'hFFFF_FFFF,
                       1'b0, 16'd0, 22'd0, 10'd0});
      plan.push_back('{1'b0, ADDR_MAX_FPS, 32'd0, 32'hFFFF_FFF0, 32'd0,
                       1'b0, 16'd0, 22'd0, 10'd0});
      plan.push_back('{1'b0, ADDR_MAX_FPS, 32'd0, 32'd6, 32'd16,
                       1'b0, 16'd0, 22'd0, 10'd0});
      plan.push_back('{1'b0, ADDR_MAX_FPS, 32'd0, 32'd25, 32'd25,
                       1'b0, 16'd0, 22'd0, 10'd0});
      plan.push_back('{1'b0, ADDR_MAX_FPS, 32'd0, 32'd1000, 32'd1025,
                       1'b0, 16'd0, 22'd0, 10'd0});
      plan.push_back('{1'b0, ADDR_MAX_FPS, 32'd0, 32'd1026, 32'd1026,
                       1'b0, 16'd0, 22'd0, 10'd0});
      plan.push_back('{1'b0, ADDR_MAX_FPS, 32'd0, 32'd1026, 32'd1026,
                       1'b0, 16'd0, 22'd0, 10'd0});
      plan.push_back('{1'b0, ADDR_MAX_FPS, 32'd0, 32'd4990, 32'd5000,
                       1'b0, 16'd0, 22'd0, 10'd0});
      plan.push_back('{1'b1, ADDR_MAX_FPS, 32'd0, 32'd0, 32'd0,
                       1'b0, 16'd0, 22'd0, 10'd0});
      plan.push_back('{1'b0, ADDR_MAX_FPS, 32'd0, 32'd6000, 32'd6000,
                       1'b0, 16'd0, 22'd0, 10'd0});
      plan.push_back('{1'b0, ADDR_MAX_FPS, 32'd0, 32'd6001, 32'd7000,
                       1'b0, 16'd0, 22'd0, 10'd0});
      plan.push_back('{1'b0, ADDR_MAX_FPS, 32'd0, 32'd7000, 32'd8000,
                       1'b0, 16'd0, 22'd0, 10'd0});
      plan.push_back('{1'b1, ADDR_MAX_FPS, 32'd1000, 32'd0, 32'd0,
                       1'b0, 16'd0, 22'd0, 10'd0});
      plan.push_back('{1'b0, ADDR_MAX_FPS, 32'd0, 32'd8001, 32'd8001,
                       1'b0, 16'd0, 22'd0, 10'd0});
      plan.push_back('{1'b1, ADDR_MAX_FPS, 32'd1023, 32'd0, 32'd0,
                       1'b0, 16'd0, 22'd0, 10'd0});
      plan.push_back('{1'b0, ADDR_MAX_FPS, 32'd0, 32'd9000, 32'd9000,
                       1'b0, 16'd0, 22'd0, 10'd0});
      plan.push_back('{1'b1, ADDR_MAX_FPS, 32'hFFFF_FC01, 32'd0, 32'd0,
                       1'b0, 16'd0, 22'd0, 10'd0});
      plan.push_back('{1'b0, ADDR_MAX_FPS, 32'd0, 32'd9500, 32'd9500,
                       1'b0, 16'd0, 22'd0, 10'd0});
      plan.push_back('{1'b1, ADDR_UNMAPPED, 32'd5, 32'd0, 32'd0,
                       1'b0, 16'd0, 22'd0, 10'd0});
      plan.push_back('{1'b0, ADDR_MAX_FPS, 32'd0, 32'd9600, 32'd9600,
                       1'b0, 16'd0, 22'd0, 10'd0});

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The limit register must read back its reset value before anything is written.
      program_fps_limit(1'b0, ADDR_MAX_FPS, '0);

      foreach (plan[i]) begin
         if (plan[i].set_limit) begin
            wait_for_results();
            program_fps_limit(1'b1, plan[i].addr, plan[i].wdata);
         end else begin
            send_frame(plan[i].start, plan[i].now, plan[i].typed,
                       frame_report_type'{plan[i].ft, plan[i].fps, plan[i].dly});
         end
      end
      directed_items = items_sent;

      // Random phases, each under its own limit: extremes and typical rates, the last one drawn at random.
      phase_limits = '{10'd0, 10'd1, 10'd1023, 10'd1000, 10'd60,
                       10'd144, 10'd2, 10'd999, 10'd30, 10'd0};
      phase_limits[RANDOM_PHASES-1] = MAX_FPS_W'($urandom_range(0, 1023));
      stamp_clock = last_stamp;

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_for_results();
         // Random upper write-data bits must be dropped by the register.
         program_fps_limit(1'b1, ADDR_MAX_FPS,
                           {22'($urandom_range(0, 22'h3F_FFFF)), phase_limits[p]});
         sent   = 0;
         held   = 1'b0;
         paused = 1'b0;
         dense  = (p % 4 == 0);
         fast   = (p % 3 == 1);
         while (sent < ITEMS_PER_PHASE) begin
            burst = $urandom_range(1, 12);
            gap   = 0;
            if (!dense) begin
               pick = $urandom_range(0, 9);
               if (pick >= 8) begin
                  gap = $urandom_range(11, 70);
               end else if (pick >= 3) begin
                  gap = $urandom_range(1, 10);
               end
            end

            // Once in two phases the receiver holds off for a long stretch while a burst keeps
            // coming, so the block fills up and stalls the request channel.
            if ((p == 2 || p == 7) && !held && sent >= 60) begin
               held      = 1'b1;
               hold_asks <= hold_asks + 1;
               burst     = 10;
            end

            // Once the sender pauses until the block has handed back every result.
            if (p == 5 && !paused && sent >= 90) begin
               paused = 1'b1;
               wait_for_results();
            end

            for (int k = 0; k < burst && sent < ITEMS_PER_PHASE; k++) begin
               // Frame-end stamps mostly advance by realistic frame times; a fraction jump far
               // enough to saturate the frame time or land anywhere in the 32-bit range. The
               // fast phases favour runs of zero and one millisecond frames to push the rate up.
               pick = $urandom_range(0, 99);
               if (fast) begin
                  pick = pick / 3;
               end
               if (pick < 12) begin
                  step = '0;
               end else if (pick < 20) begin
                  step = 1;
               end else if (pick < 60) begin
                  step = $urandom_range(2, 60);
               end else if (pick < 80) begin
                  step = $urandom_range(61, 65535);
               end else if (pick < 90) begin
                  step = $urandom_range(65536, 32'hFFFF_FFFF);
               end else begin
                  step = $urandom();
               end
               stamp_clock = stamp_clock + step;

               // The elapsed time mostly sits around the budget, so both a real wait and an
               // overrun appear; a start stamp after now is also offered.
               budget = BUDGET_MS / ((fps_limit == 0) ? 1 : fps_limit);
               pick   = $urandom_range(0, 99);
               if (pick < 60) begin
                  elapsed = $urandom_range(0, budget + 3);
               end else if (pick < 72) begin
                  elapsed = '0;
               end else if (pick < 88) begin
                  elapsed = $urandom();
               end else begin
                  elapsed = 32'd0 - $urandom_range(1, 100);
               end
               send_frame(stamp_clock - elapsed, stamp_clock, 1'b0, '0);
               sent++;
            end

            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d frame transactions (%0d from the directed table), %0d results checked,",
               items_sent, directed_items, results_checked);
      $display("%0d register writes over %0d limit phases with two long receiver hold-offs.",
               csr_writes, RANDOM_PHASES);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
